[rtl/core/eamf_pkg.sv]
package eamf_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int PIXEL_BITS = 16;

    localparam int DIM_W     = 11;
    localparam int COL_AW    = $clog2(MAX_COLS);
    localparam int OUT_ROW_W = $clog2(MAX_ROWS);
    localparam int IN_ROW_W  = $clog2(MAX_ROWS + 2);

    localparam int CSUM_W      = PIXEL_BITS + 2;
    localparam int TSUM_W      = PIXEL_BITS + 4;
    localparam int MAG_W       = PIXEL_BITS + 3;
    localparam int RECIP_SHIFT = MAG_W + 5;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUOT_W      = PIXEL_BITS + 1;

    localparam longint RECIP_ONE = longint'(1) << RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(RECIP_ONE);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((RECIP_ONE + 1) / 2);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((RECIP_ONE + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((RECIP_ONE + 3) / 4);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((RECIP_ONE + 5) / 6);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((RECIP_ONE + 8) / 9);

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_FRAME_COLS = 1'b0,
        REG_FRAME_ROWS = 1'b1
    } cfg_reg_t;

    typedef logic signed [PIXEL_BITS-1:0] pixel_t;

    // Window indexed [row][col]; column 2 holds the newest samples.
    typedef logic [2:0][2:0][PIXEL_BITS-1:0] win_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } nbr_mask_t;

    typedef struct packed {
        logic              valid;
        logic [COL_AW-1:0] col;
        pixel_t            px;
        logic              emit;
        nbr_mask_t         mask;
        logic              last;
    } line_req_t;

    typedef struct packed {
        logic      valid;
        nbr_mask_t mask;
        logic      last;
    } win_req_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] rows_n,
                                                    input logic [1:0] cols_n);
        logic [RECIP_W-1:0] r;
        case ({rows_n, cols_n})
            4'b0101: r = RECIP_1;
            4'b0110: r = RECIP_2;
            4'b1001: r = RECIP_2;
            4'b0111: r = RECIP_3;
            4'b1101: r = RECIP_3;
            4'b1010: r = RECIP_4;
            4'b1011: r = RECIP_6;
            4'b1110: r = RECIP_6;
            4'b1111: r = RECIP_9;
            default: r = RECIP_1;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/edge_aware_3x3_mean_filter.sv]
// Channel  Dir  Handshake            Contents
// s_       in   s_tvalid / s_tready  s_tdata = pixel, s_tuser = opcode
// m_       out  m_tvalid / m_tready  m_tdata = mean_value, m_tlast = frame_end
// cfg_     in   cfg_wr_en            cfg_addr = register index, cfg_wr_data = value
//
// One request is accepted per cycle while s_tready is high; the result that a request
// causes passes the line store read, the window register and the sum and divide stages.
// Reset is synchronous and active low; it clears the positions and stage valids,
// sets the frame to 640 x 480 and leaves the line stores as they are.
// A stalled result holds its stages; s_tready falls only once every stage is full.
module edge_aware_3x3_mean_filter
    import eamf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_addr,
    input  logic [DIM_W-1:0]      cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_BITS-1:0] s_tdata,   // [15:0] pixel
    input  logic                  s_tuser,   // [0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_BITS-1:0] m_tdata,   // [15:0] mean_value
    output logic                  m_tlast
);

    line_req_t req;
    win_t      win;
    win_req_t  win_req;
    logic      take;
    pixel_t    mean_value;

    eamf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .opcode      (opcode_t'(s_tuser)),
        .pixel       (pixel_t'(s_tdata)),
        .req         (req)
    );

    eamf_line u_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .take    (take),
        .s_ready (s_tready),
        .win     (win),
        .win_req (win_req)
    );

    eamf_mean u_mean (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .win        (win),
        .win_req    (win_req),
        .take       (take),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .mean_value (mean_value),
        .frame_end  (m_tlast)
    );

    assign m_tdata = mean_value;

endmodule

[rtl/core/eamf_ctrl.sv]
module eamf_ctrl
    import eamf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_addr,
    input  logic [DIM_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  opcode_t          opcode,
    input  pixel_t           pixel,
    output line_req_t        req
);

    logic [DIM_W-1:0]     cols_reg, cols_next;
    logic [DIM_W-1:0]     rows_reg, rows_next;
    logic [COL_AW-1:0]    in_col_reg, in_col_next;
    logic [IN_ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_AW-1:0]    out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;

    logic accept, is_pixel, past_frame, ignore, emit;
    logic in_col_end, out_col_end, out_row_end, last_pos;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_comb begin
        accept      = s_valid && s_ready;
        is_pixel    = opcode == OP_PIXEL;
        past_frame  = in_row_reg >= IN_ROW_W'(rows_reg);
        ignore      = !is_pixel && !past_frame;
        emit        = (in_row_reg >= IN_ROW_W'(2))
                      || (in_row_reg == IN_ROW_W'(1) && in_col_reg != '0);
        in_col_end  = (DIM_W'(in_col_reg) + DIM_W'(1)) >= cols_reg;
        out_col_end = (DIM_W'(out_col_reg) + DIM_W'(1)) >= cols_reg;
        out_row_end = (DIM_W'(out_row_reg) + DIM_W'(1)) >= rows_reg;
        last_pos    = out_row_end && out_col_end;
    end

    always_comb begin
        req.valid       = accept && !ignore;
        req.col         = in_col_reg;
        req.px          = (is_pixel && !past_frame) ? pixel : '0;
        req.emit        = emit;
        req.mask.top    = out_row_reg != '0;
        req.mask.bottom = !out_row_end;
        req.mask.left   = out_col_reg != '0;
        req.mask.right  = !out_col_end;
        req.last        = emit && last_pos;
    end

    always_comb begin
        cols_next    = cols_reg;
        rows_next    = rows_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_FRAME_COLS: cols_next = clamp_dim(cfg_wr_data, DIM_W'(MAX_COLS));
                REG_FRAME_ROWS: rows_next = clamp_dim(cfg_wr_data, DIM_W'(MAX_ROWS));
                default: ;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (accept && !ignore) begin
            if (in_col_end) begin
                in_col_next = '0;
                in_row_next = in_row_reg + IN_ROW_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_AW'(1);
            end
            if (emit) begin
                if (out_col_end) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OUT_ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_AW'(1);
                end
                if (last_pos) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg    <= DIM_W'(640);
            rows_reg    <= DIM_W'(480);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

[rtl/core/eamf_line.sv]
module eamf_line
    import eamf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  line_req_t req,
    input  logic      take,
    output logic      s_ready,
    output win_t      win,
    output win_req_t  win_req
);

    logic [PIXEL_BITS-1:0] upper_mem  [MAX_COLS];
    logic [PIXEL_BITS-1:0] middle_mem [MAX_COLS];
    logic [PIXEL_BITS-1:0] upper_rd_reg, middle_rd_reg;

    logic                  p1_valid_reg, p1_valid_next;
    logic [COL_AW-1:0]     p1_col_reg;
    pixel_t                p1_px_reg;
    logic                  p1_emit_reg;
    nbr_mask_t             p1_mask_reg;
    logic                  p1_last_reg;
    logic                  p1_fwd_reg;
    logic [PIXEL_BITS-1:0] fwd_up_reg, fwd_mid_reg;

    logic                  p2_valid_reg, p2_valid_next;
    nbr_mask_t             p2_mask_reg;
    logic                  p2_last_reg;
    win_t                  win_reg, win_next;

    logic                  p1_ready, p2_ready, p1_move, fwd_hit;
    logic [PIXEL_BITS-1:0] up_eff, mid_eff;

    always_comb begin
        p2_ready      = !p2_valid_reg || take;
        p1_ready      = !p1_valid_reg || p2_ready;
        p1_move       = p1_valid_reg && p2_ready;
        up_eff        = p1_fwd_reg ? fwd_up_reg : upper_rd_reg;
        mid_eff       = p1_fwd_reg ? fwd_mid_reg : middle_rd_reg;
        fwd_hit       = p1_valid_reg && (p1_col_reg == req.col);
        p1_valid_next = p1_ready ? req.valid : p1_valid_reg;
        p2_valid_next = p2_ready ? (p1_valid_reg && p1_emit_reg) : p2_valid_reg;
    end

    always_comb begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_eff;
        win_next[1][2] = mid_eff;
        win_next[2][2] = p1_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            upper_rd_reg <= upper_mem[req.col];
        end
        if (p1_move) begin
            upper_mem[p1_col_reg] <= mid_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            middle_rd_reg <= middle_mem[req.col];
        end
        if (p1_move) begin
            middle_mem[p1_col_reg] <= p1_px_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            p1_col_reg  <= req.col;
            p1_px_reg   <= req.px;
            p1_emit_reg <= req.emit;
            p1_mask_reg <= req.mask;
            p1_last_reg <= req.last;
            p1_fwd_reg  <= fwd_hit;
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= p1_px_reg;
        end
        if (p1_move) begin
            win_reg     <= win_next;
            p2_mask_reg <= p1_mask_reg;
            p2_last_reg <= p1_last_reg;
        end
    end

    assign s_ready       = p1_ready;
    assign win           = win_reg;
    assign win_req.valid = p2_valid_reg;
    assign win_req.mask  = p2_mask_reg;
    assign win_req.last  = p2_last_reg;

endmodule

[rtl/core/eamf_mean.sv]
module eamf_mean
    import eamf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  win_t     win,
    input  win_req_t win_req,
    output logic     take,
    output logic     m_valid,
    input  logic     m_ready,
    output pixel_t   mean_value,
    output logic     frame_end
);

    typedef logic signed [CSUM_W-1:0] csum_t;
    typedef logic signed [TSUM_W-1:0] tsum_t;

    logic                     p3_valid_reg, p3_valid_next;
    nbr_mask_t                p3_mask_reg;
    logic                     p3_last_reg;
    csum_t                    csum_reg [3];
    csum_t                    csum_next [3];

    logic                     p4_valid_reg, p4_valid_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     p4_neg_reg, p4_neg_next;
    logic [RECIP_W-1:0]       recip_reg, recip_next;
    logic                     p4_last_reg;

    logic                     p5_valid_reg, p5_valid_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic                     p5_neg_reg;
    logic                     p5_last_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [PIXEL_BITS-1:0]    out_value_reg, out_value_next;
    logic                     out_last_reg;

    logic                     out_ready, p5_ready, p4_ready, p3_ready;
    tsum_t                    part_l, part_c, part_r, total;
    logic [1:0]               rows_n, cols_n;
    logic [QUOT_W-1:0]        quot, signed_quot;

    always_comb begin
        out_ready = !out_valid_reg || m_ready;
        p5_ready  = !p5_valid_reg || out_ready;
        p4_ready  = !p4_valid_reg || p5_ready;
        p3_ready  = !p3_valid_reg || p4_ready;
        p3_valid_next  = p3_ready ? win_req.valid : p3_valid_reg;
        p4_valid_next  = p4_ready ? p3_valid_reg : p4_valid_reg;
        p5_valid_next  = p5_ready ? p4_valid_reg : p5_valid_reg;
        out_valid_next = out_ready ? p5_valid_reg : out_valid_reg;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            csum_next[k] = csum_t'(pixel_t'(win[1][k]));
            if (win_req.mask.top) begin
                csum_next[k] = csum_next[k] + csum_t'(pixel_t'(win[0][k]));
            end
            if (win_req.mask.bottom) begin
                csum_next[k] = csum_next[k] + csum_t'(pixel_t'(win[2][k]));
            end
        end
    end

    always_comb begin
        part_l      = p3_mask_reg.left ? tsum_t'(csum_reg[0]) : tsum_t'(0);
        part_c      = tsum_t'(csum_reg[1]);
        part_r      = p3_mask_reg.right ? tsum_t'(csum_reg[2]) : tsum_t'(0);
        total       = part_l + part_c + part_r;
        p4_neg_next = total[TSUM_W-1];
        mag_next    = p4_neg_next ? MAG_W'(-total) : MAG_W'(total);
        rows_n      = 2'd1 + 2'(p3_mask_reg.top) + 2'(p3_mask_reg.bottom);
        cols_n      = 2'd1 + 2'(p3_mask_reg.left) + 2'(p3_mask_reg.right);
        recip_next  = recip_of(rows_n, cols_n);
    end

    always_comb begin
        prod_next      = PROD_W'(mag_reg) * PROD_W'(recip_reg);
        quot           = prod_reg[RECIP_SHIFT +: QUOT_W];
        signed_quot    = p5_neg_reg ? (~quot + QUOT_W'(1)) : quot;
        out_value_next = signed_quot[PIXEL_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p3_valid_reg  <= p3_valid_next;
            p4_valid_reg  <= p4_valid_next;
            p5_valid_reg  <= p5_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p3_ready && win_req.valid) begin
            csum_reg    <= csum_next;
            p3_mask_reg <= win_req.mask;
            p3_last_reg <= win_req.last;
        end
        if (p4_ready && p3_valid_reg) begin
            mag_reg     <= mag_next;
            p4_neg_reg  <= p4_neg_next;
            recip_reg   <= recip_next;
            p4_last_reg <= p3_last_reg;
        end
        if (p5_ready && p4_valid_reg) begin
            prod_reg    <= prod_next;
            p5_neg_reg  <= p4_neg_reg;
            p5_last_reg <= p4_last_reg;
        end
        if (out_ready && p5_valid_reg) begin
            out_value_reg <= out_value_next;
            out_last_reg  <= p5_last_reg;
        end
    end

    assign take       = p3_ready;
    assign m_valid    = out_valid_reg;
    assign mean_value = out_value_reg;
    assign frame_end  = out_last_reg;

endmodule

[rtl/core/eamf_checker.sv]
module eamf_checker
    import eamf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [PIXEL_BITS-1:0] m_tdata,
    input logic                  m_tlast
);

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Reset empties the output stage.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With the output stage empty, no stage can be blocking the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output is empty");

    // A request taken with the output empty and free cannot stall the next one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> s_tready || m_tvalid)
        else $error("input blocked without a pending result");

endmodule

bind edge_aware_3x3_mean_filter eamf_checker u_eamf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
